// ----- hw/rtl/pli_pkg.sv -----
package pli_pkg;

    localparam int MAX_POINTS_DEF = 64;
    localparam int COUNT_W        = 7;
    localparam int IDX_W          = 6;
    localparam int DATA_W         = 32;
    localparam int IN_TDATA_W     = 104;
    localparam int OUT_TDATA_W    = 40;
    localparam int OUT_TUSER_W    = 2;
    localparam int MUL_STEPS      = 33;
    localparam int DIV_STEPS      = 66;
    localparam int CNT_STEP_W     = 7;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } t_opcode;

    typedef enum logic [2:0] {
        MD_IDLE,
        MD_PREP,
        MD_MUL,
        MD_DIV,
        MD_DONE
    } t_md_state;

    typedef struct packed {
        logic               vld;
        logic signed [31:0] q;
        logic               found;
        logic        [32:0] best;
        logic               grab;
        logic signed [31:0] xl;
        logic signed [31:0] yl;
        logic signed [31:0] xh;
        logic signed [31:0] yh;
        logic signed [31:0] xp;
        logic signed [31:0] yp;
        logic signed [31:0] xr;
        logic signed [31:0] yr;
    } t_token;

    typedef struct packed {
        logic signed [31:0] q;
        logic signed [31:0] xl;
        logic signed [31:0] yl;
        logic signed [31:0] xh;
        logic signed [31:0] yh;
        logic        [5:0]  seg;
        logic               below;
    } t_job;

    typedef struct packed {
        logic signed [31:0] value;
        logic        [5:0]  seg;
        logic               below;
        logic               zero;
    } t_result;

    typedef struct packed {
        logic idle;
        logic done;
    } t_md_status;

endpackage

// ----- hw/rtl/piecewise_linear_interpolator.sv -----
// load word: written into its cell register when taken, next word taken the cycle after
// query word: result formed as below, with no multiply or divide on a zero-width segment;
//   next word taken only once the result has moved into the output register
// the token walks the row of MAX_POINTS cells, then a bit-serial 33-step multiply
//   and 66-step divide form the result; a result waiting outside holds back the next one and input
// reset: control cleared, point count back to 2, table undefined until loaded
module piecewise_linear_interpolator #(
    parameter int MAX_POINTS = pli_pkg::MAX_POINTS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // point_index, point_x, point_y, query_value
    input  logic [pli_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    // opcode
    input  logic                               i_s_axis_tuser,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // result_value, segment_index
    output logic [pli_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,
    // below_range, zero_width
    output logic [pli_pkg::OUT_TUSER_W-1:0]    o_m_axis_tuser,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [pli_pkg::COUNT_W-1:0]        i_cfg_data
);
    import pli_pkg::*;

    localparam int SEG_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W = $clog2(MAX_POINTS + 1);

    logic               r_busy;
    logic [CNT_W-1:0]   r_count;
    logic               r_out_vld;
    t_result            r_out;

    logic               accept;
    t_opcode            opcode;
    logic               wr_en;
    logic               take;
    t_token             tok [0:MAX_POINTS];
    logic [SEG_W-1:0]   seg [0:MAX_POINTS];
    t_token             te;
    logic               last;
    t_job               job;
    t_md_status         md_status;
    t_result            md_result;

    assign o_s_axis_tready = !r_busy;
    assign o_cfg_ready     = 1'b1;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign opcode          = t_opcode'(i_s_axis_tuser);
    assign wr_en           = accept && (opcode == OP_LOAD);

    always_comb begin
        tok[0]     = '0;
        tok[0].vld = accept && (opcode == OP_QUERY);
        tok[0].q   = i_s_axis_tdata[101:70];
        seg[0]     = '0;
    end

    for (genvar g = 0; g < MAX_POINTS; g++) begin : g_cell
        pli_cell #(
            .IDX   (g),
            .SEG_W (SEG_W),
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_wr_en  (wr_en),
            .i_wr_idx (i_s_axis_tdata[5:0]),
            .i_wr_x   (i_s_axis_tdata[37:6]),
            .i_wr_y   (i_s_axis_tdata[69:38]),
            .i_count  (r_count),
            .i_tok    (tok[g]),
            .i_seg    (seg[g]),
            .o_tok    (tok[g+1]),
            .o_seg    (seg[g+1])
        );
    end

    assign te   = tok[MAX_POINTS];
    assign last = (32'(seg[MAX_POINTS]) == 32'(r_count) - 1);

    always_comb begin
        job.q     = te.q;
        job.below = !te.found;
        if (last) begin
            job.xl  = te.xp;
            job.yl  = te.yp;
            job.xh  = te.xl;
            job.yh  = te.yl;
            job.seg = IDX_W'(32'(r_count) - 2);
        end else begin
            job.xl  = te.xl;
            job.yl  = te.yl;
            job.xh  = te.xh;
            job.yh  = te.yh;
            job.seg = IDX_W'(seg[MAX_POINTS]);
        end
    end

    pli_muldiv u_muldiv (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (te.vld),
        .i_job    (job),
        .i_take   (take),
        .o_status (md_status),
        .o_result (md_result)
    );

    assign take = md_status.done && (!r_out_vld || i_m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_count   <= CNT_W'(2);
            r_out_vld <= 1'b0;
        end else begin
            if (accept && (opcode == OP_QUERY)) begin
                r_busy <= 1'b1;
            end else if (take) begin
                r_busy <= 1'b0;
            end
            if (i_cfg_valid) begin
                priority if (i_cfg_data < COUNT_W'(2)) begin
                    r_count <= CNT_W'(2);
                end else if (32'(i_cfg_data) > MAX_POINTS) begin
                    r_count <= CNT_W'(MAX_POINTS);
                end else begin
                    r_count <= CNT_W'(i_cfg_data);
                end
            end
            if (take) begin
                r_out_vld <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) r_out <= md_result;
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {2'b00, r_out.seg, r_out.value};
    assign o_m_axis_tuser  = {r_out.zero, r_out.below};

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        te.vld |-> md_status.idle)
        else $error("token left the cell row while the arithmetic unit was busy");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (opcode == OP_QUERY)) |=> r_busy)
        else $error("query accepted without marking the block busy");

    a_result_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (md_status.done && !take) |=> md_status.done)
        else $error("finished result dropped before the output register took it");

endmodule

// ----- hw/rtl/pli_cell.sv -----
module pli_cell #(
    parameter int IDX   = 0,
    parameter int SEG_W = 6,
    parameter int CNT_W = 7
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_wr_en,
    input  logic [pli_pkg::IDX_W-1:0]   i_wr_idx,
    input  logic signed [31:0]          i_wr_x,
    input  logic signed [31:0]          i_wr_y,
    input  logic [CNT_W-1:0]            i_count,
    input  pli_pkg::t_token             i_tok,
    input  logic [SEG_W-1:0]            i_seg,
    output pli_pkg::t_token             o_tok,
    output logic [SEG_W-1:0]            o_seg
);
    import pli_pkg::*;

    logic signed [31:0] r_x;
    logic signed [31:0] r_y;
    t_token             r_tok;
    t_token             n_tok;
    logic [SEG_W-1:0]   r_seg;
    logic [SEG_W-1:0]   n_seg;
    logic signed [32:0] gap;
    logic               active;
    logic               better;
    logic               capture;

    assign gap     = {i_tok.q[31], i_tok.q} - {r_x[31], r_x};
    assign active  = (32'(i_count) > IDX);
    assign better  = active && (gap > 33'sd0) &&
                     (!i_tok.found || ($unsigned(gap) < i_tok.best));
    assign capture = active && (better || (IDX == 0));

    always_comb begin
        n_tok = i_tok;
        n_seg = i_seg;
        if (active) begin
            n_tok.xr = r_x;
            n_tok.yr = r_y;
        end
        priority if (capture) begin
            n_tok.xl   = r_x;
            n_tok.yl   = r_y;
            n_tok.xp   = i_tok.xr;
            n_tok.yp   = i_tok.yr;
            n_tok.grab = 1'b1;
            n_seg      = SEG_W'(IDX);
            if (better) begin
                n_tok.found = 1'b1;
                n_tok.best  = $unsigned(gap);
            end
        end else if (active && i_tok.grab) begin
            n_tok.xh   = r_x;
            n_tok.yh   = r_y;
            n_tok.grab = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en && (32'(i_wr_idx) == IDX)) begin
            r_x <= i_wr_x;
            r_y <= i_wr_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.vld <= 1'b0;
        end else begin
            r_tok <= n_tok;
            r_seg <= n_seg;
        end
    end

    assign o_tok = r_tok;
    assign o_seg = r_seg;

endmodule

// ----- hw/rtl/pli_muldiv.sv -----
module pli_muldiv (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  pli_pkg::t_job       i_job,
    input  logic                i_take,
    output pli_pkg::t_md_status o_status,
    output pli_pkg::t_result    o_result
);
    import pli_pkg::*;

    t_md_state                 r_state;
    t_md_state                 n_state;
    t_job                      r_job;
    logic                      r_zero;
    logic                      r_neg;
    logic [65:0]               r_mcand;
    logic [32:0]               r_mplier;
    logic [65:0]               r_acc;
    logic [32:0]               r_dvs;
    logic [32:0]               r_rem;
    logic [33:0]               r_quo;
    logic                      r_ovf;
    logic [CNT_STEP_W-1:0]     r_cnt;

    logic signed [32:0]        a_s;
    logic signed [32:0]        b_s;
    logic signed [32:0]        d_s;
    logic                      zero_c;
    logic [33:0]               rem_sh;
    logic                      ge;
    logic [33:0]               mag;
    logic signed [35:0]        sum;
    logic signed [35:0]        delta;

    function automatic logic [32:0] umag(input logic signed [32:0] v);
        logic [32:0] r;
        r = v[32] ? $unsigned(-v) : $unsigned(v);
        return r;
    endfunction

    assign a_s    = {r_job.q[31], r_job.q} - {r_job.xl[31], r_job.xl};
    assign b_s    = {r_job.yh[31], r_job.yh} - {r_job.yl[31], r_job.yl};
    assign d_s    = {r_job.xh[31], r_job.xh} - {r_job.xl[31], r_job.xl};
    assign zero_c = (d_s == 33'sd0);
    assign rem_sh = {r_rem, r_acc[65]};
    assign ge     = (rem_sh >= {1'b0, r_dvs});

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            MD_IDLE: if (i_start) n_state = MD_PREP;
            MD_PREP: n_state = zero_c ? MD_DONE : MD_MUL;
            MD_MUL:  if (r_cnt == CNT_STEP_W'(MUL_STEPS - 1)) n_state = MD_DIV;
            MD_DIV:  if (r_cnt == CNT_STEP_W'(DIV_STEPS - 1)) n_state = MD_DONE;
            MD_DONE: if (i_take) n_state = MD_IDLE;
            default: n_state = MD_IDLE;
        endcase
    end

    always_comb begin
        mag   = r_zero ? 34'd0 : (r_ovf ? '1 : r_quo);
        delta = r_neg ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
        sum   = {{4{r_job.yl[31]}}, r_job.yl} + delta;
        o_status.idle  = (r_state == MD_IDLE);
        o_status.done  = (r_state == MD_DONE);
        o_result.seg   = r_job.seg;
        o_result.below = r_job.below;
        o_result.zero  = r_zero;
        priority if (sum > 36'sd2147483647) begin
            o_result.value = 32'sh7fffffff;
        end else if (sum < -36'sd2147483648) begin
            o_result.value = 32'sh80000000;
        end else begin
            o_result.value = sum[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= MD_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            MD_IDLE: begin
                if (i_start) r_job <= i_job;
            end
            MD_PREP: begin
                r_zero   <= zero_c;
                r_neg    <= a_s[32] ^ b_s[32] ^ d_s[32];
                r_mcand  <= {33'd0, umag(a_s)};
                r_mplier <= umag(b_s);
                r_dvs    <= umag(d_s);
                r_acc    <= '0;
                r_rem    <= '0;
                r_quo    <= '0;
                r_ovf    <= 1'b0;
                r_cnt    <= '0;
            end
            MD_MUL: begin
                if (r_mplier[0]) r_acc <= r_acc + r_mcand;
                r_mcand  <= {r_mcand[64:0], 1'b0};
                r_mplier <= {1'b0, r_mplier[32:1]};
                r_cnt    <= (r_cnt == CNT_STEP_W'(MUL_STEPS - 1)) ? '0 : r_cnt + 1'b1;
            end
            MD_DIV: begin
                r_rem <= ge ? 33'(rem_sh - {1'b0, r_dvs}) : rem_sh[32:0];
                r_acc <= {r_acc[64:0], 1'b0};
                r_quo <= {r_quo[32:0], ge};
                r_ovf <= r_ovf | r_quo[33];
                r_cnt <= r_cnt + 1'b1;
            end
            MD_DONE: begin
                r_cnt <= '0;
            end
            default: begin
                r_cnt <= '0;
            end
        endcase
    end

endmodule
